### sv/uoa_pkg.sv
// uoa_pkg: shared types, codes and constants of the ultrasonic obstacle avoider
// holds the sample and result word types and the echo-width to distance conversion
// no dependencies
package uoa_pkg;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        echo_ok;
    logic [15:0] echo_us;
  } sample_t;

  typedef struct packed {
    logic [2:0]  motor_cmd;
    logic [7:0]  left_duty;
    logic [7:0]  right_duty;
    logic [14:0] distance_q6;
    logic [1:0]  zone;
  } result_t;

  localparam logic [2:0] CMD_STOP  = 3'd0;
  localparam logic [2:0] CMD_FWD   = 3'd1;
  localparam logic [2:0] CMD_BACK  = 3'd2;
  localparam logic [2:0] CMD_LEFT  = 3'd3;
  localparam logic [2:0] CMD_RIGHT = 3'd4;

  localparam logic [1:0] ZONE_BACK  = 2'd0;
  localparam logic [1:0] ZONE_FRONT = 2'd1;
  localparam logic [1:0] ZONE_CLEAR = 2'd2;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_BACK_TIME = 3'd1;
  localparam logic [2:0] REG_TURN_TIME = 3'd2;
  localparam logic [2:0] REG_MIN_DUTY  = 3'd3;
  localparam logic [2:0] REG_FAST_DUTY = 3'd4;
  localparam logic [2:0] REG_SLOW_DUTY = 3'd5;

  localparam logic [8:0]  THRESHOLD_RESET = 9'd20;
  localparam logic [15:0] BACK_TIME_RESET = 16'd400;
  localparam logic [15:0] TURN_TIME_RESET = 16'd80;
  localparam logic [7:0]  MIN_DUTY_RESET  = 8'd50;
  localparam logic [7:0]  FAST_DUTY_RESET = 8'd70;
  localparam logic [7:0]  SLOW_DUTY_RESET = 8'd50;

  localparam int unsigned Q6_MAX = 25600;
  localparam logic [14:0] Q6_BACK_ZONE = 15'd640;

  // echo widths outside this range land on the 2 cm / 400 cm clamps
  localparam logic [15:0] US_MIN = 16'd118;
  localparam logic [15:0] US_MAX = 16'd23529;
  // ceil(2^31 / 250), exact floor divide for operands below 2^23
  localparam logic [23:0] RECIP_250 = 24'd8589935;
  localparam int RECIP_250_SHIFT = 31;

  // round(us * 0.017 * 64) clamped to 2..400 cm, as (us*272 + 125) / 250
  function automatic logic [14:0] width_to_q6(input logic [15:0] us);
    logic [14:0] us_c;
    logic [22:0] num;
    logic [46:0] prod;
    begin
      if (us < US_MIN) begin
        us_c = US_MIN[14:0];
      end else if (us > US_MAX) begin
        us_c = US_MAX[14:0];
      end else begin
        us_c = us[14:0];
      end
      num = (23'(us_c) << 8) + (23'(us_c) << 4) + 23'd125;
      prod = 47'(num) * 47'(RECIP_250);
      width_to_q6 = 15'(prod >> RECIP_250_SHIFT);
    end
  endfunction

endpackage

### sv/ultrasonic_obstacle_avoider_core.sv
// ultrasonic_obstacle_avoider_core: top level of the ultrasonic obstacle avoider
// converts ranging samples to filtered distance and runs the avoidance phase machine
// depends on uoa_pkg and uoa_filter
//
// usage
// sample channel (sample_valid/sample_ready/sample): one word per ranging sample,
//   carrying the ms timestamp, the echo ok flag and the echo width in us
// result channel (result_valid/result_ready/result): exactly one word per sample,
//   with motor command, both duties, filtered distance and zone
// cfg port: cfg_we writes cfg_data into the register selected by cfg_index;
//   write only while no sample is in flight
// latency: a sample accepted at one clock edge shows its result word after the next edge
// throughput: one sample per cycle; the echo conversion multiply sits before the
//   input register and the window average multiply before the result register
// stall: while the result word is not taken, the input register holds one more
//   sample and sample_ready drops only when both are occupied
// reset (rst, synchronous): registers return to their default values, the window
//   empties, the last distance is zero, the phase is idle and the first turn is right
module ultrasonic_obstacle_avoider_core #(
  parameter int WINDOW_DEPTH = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  uoa_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output uoa_pkg::result_t result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BACK,
    PH_TURN
  } phase_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        echo_good;
    logic [14:0] raw_q6;
  } stage_t;

  logic [8:0]  threshold_cm;
  logic [15:0] back_time_ms;
  logic [15:0] turn_time_ms;
  logic [7:0]  duty_floor;
  logic [7:0]  fast_duty;
  logic [7:0]  slow_duty;

  logic        pipe_valid;
  stage_t      pipe;
  stage_t      pipe_next;
  logic        advance;

  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] phase_start;
  logic [31:0] phase_start_next;
  logic        turn_left;
  logic        turn_left_next;
  logic [14:0] last_distance;
  logic [14:0] last_distance_next;

  logic [14:0] filtered_q6;
  logic [14:0] dist_q6;
  logic [14:0] thr_q6;
  logic [31:0] elapsed;
  logic [7:0]  fast_f;
  logic [7:0]  slow_f;
  uoa_pkg::result_t result_next;

  assign advance      = pipe_valid && (!result_valid || result_ready);
  assign sample_ready = !pipe_valid || advance;

  assign pipe_next.now_ms    = sample.now_ms;
  assign pipe_next.echo_good = sample.echo_ok && (sample.echo_us != 16'd0);
  assign pipe_next.raw_q6    = uoa_pkg::width_to_q6(sample.echo_us);

  uoa_filter #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .write_en   (advance && pipe.echo_good),
    .raw_q6     (pipe.raw_q6),
    .filtered_q6(filtered_q6)
  );

  assign dist_q6 = pipe.echo_good ? filtered_q6 : last_distance;
  assign thr_q6  = {threshold_cm, 6'd0};
  assign elapsed = pipe.now_ms - phase_start;
  assign fast_f  = (fast_duty < duty_floor) ? duty_floor : fast_duty;
  assign slow_f  = (slow_duty < duty_floor) ? duty_floor : slow_duty;
  assign last_distance_next = dist_q6;

  always_comb begin
    phase_next       = phase;
    phase_start_next = phase_start;
    turn_left_next   = turn_left;
    result_next.motor_cmd   = uoa_pkg::CMD_STOP;
    result_next.left_duty   = 8'd0;
    result_next.right_duty  = 8'd0;
    result_next.distance_q6 = dist_q6;
    if (dist_q6 < uoa_pkg::Q6_BACK_ZONE) begin
      result_next.zone = uoa_pkg::ZONE_BACK;
    end else if (dist_q6 < thr_q6) begin
      result_next.zone = uoa_pkg::ZONE_FRONT;
    end else begin
      result_next.zone = uoa_pkg::ZONE_CLEAR;
    end
    unique case (phase)
      PH_BACK: begin
        if (elapsed < 32'(back_time_ms)) begin
          result_next.motor_cmd  = uoa_pkg::CMD_BACK;
          result_next.left_duty  = fast_f;
          result_next.right_duty = fast_f;
        end else begin
          phase_next       = PH_TURN;
          phase_start_next = pipe.now_ms;
        end
      end
      PH_TURN: begin
        if (elapsed < 32'(turn_time_ms)) begin
          if (turn_left) begin
            result_next.motor_cmd  = uoa_pkg::CMD_LEFT;
            result_next.left_duty  = slow_f;
            result_next.right_duty = fast_f;
          end else begin
            result_next.motor_cmd  = uoa_pkg::CMD_RIGHT;
            result_next.left_duty  = fast_f;
            result_next.right_duty = slow_f;
          end
        end else begin
          turn_left_next = !turn_left;
          phase_next     = PH_IDLE;
          result_next.motor_cmd  = uoa_pkg::CMD_FWD;
          result_next.left_duty  = fast_f;
          result_next.right_duty = fast_f;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (dist_q6 < thr_q6) begin
          phase_next       = PH_BACK;
          phase_start_next = pipe.now_ms;
        end else begin
          result_next.motor_cmd  = uoa_pkg::CMD_FWD;
          result_next.left_duty  = fast_f;
          result_next.right_duty = fast_f;
        end
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_cm <= uoa_pkg::THRESHOLD_RESET;
      back_time_ms <= uoa_pkg::BACK_TIME_RESET;
      turn_time_ms <= uoa_pkg::TURN_TIME_RESET;
      duty_floor   <= uoa_pkg::MIN_DUTY_RESET;
      fast_duty    <= uoa_pkg::FAST_DUTY_RESET;
      slow_duty    <= uoa_pkg::SLOW_DUTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uoa_pkg::REG_THRESHOLD: threshold_cm <= cfg_data[8:0];
        uoa_pkg::REG_BACK_TIME: back_time_ms <= cfg_data;
        uoa_pkg::REG_TURN_TIME: turn_time_ms <= cfg_data;
        uoa_pkg::REG_MIN_DUTY:  duty_floor   <= cfg_data[7:0];
        uoa_pkg::REG_FAST_DUTY: fast_duty    <= cfg_data[7:0];
        uoa_pkg::REG_SLOW_DUTY: slow_duty    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (sample_ready) begin
      pipe_valid <= sample_valid;
    end
    if (sample_valid && sample_ready) begin
      pipe <= pipe_next;
    end
  end

  // phase machine and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_start   <= '0;
      turn_left     <= 1'b0;
      last_distance <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (advance) begin
        phase         <= phase_next;
        phase_start   <= phase_start_next;
        turn_left     <= turn_left_next;
        last_distance <= last_distance_next;
        result_valid  <= 1'b1;
      end else if (result_ready) begin
        result_valid  <= 1'b0;
      end
    end
    if (advance) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_stop_zero_duty: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.motor_cmd == uoa_pkg::CMD_STOP)
      |-> (result.left_duty == 8'd0) && (result.right_duty == 8'd0))
    else $error("stop word carries nonzero duty");

  a_back_zone_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.zone == uoa_pkg::ZONE_BACK)
      |-> (result.distance_q6 < uoa_pkg::Q6_BACK_ZONE))
    else $error("back zone with distance of 10 cm or more");

  a_distance_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.distance_q6 <= 15'(uoa_pkg::Q6_MAX)))
    else $error("distance above 400 cm");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> pipe_valid && result_valid && !result_ready)
    else $error("input stalled without output backpressure");

  a_turn_toggle: assert property (@(posedge clk) disable iff (rst)
    advance && (phase == PH_TURN) && (phase_next == PH_IDLE)
      |=> (turn_left != $past(turn_left)))
    else $error("turn direction did not alternate");
`endif

endmodule

### sv/uoa_filter.sv
// uoa_filter: moving-average window over converted distance samples
// keeps a running window sum and divides it by a reciprocal multiply
// depends on uoa_pkg
module uoa_filter #(
  parameter int WINDOW_DEPTH = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [14:0] raw_q6,
  output logic [14:0] filtered_q6
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
  localparam int SUM_W =
    $clog2(WINDOW_DEPTH * uoa_pkg::Q6_MAX + WINDOW_DEPTH / 2 + 1);
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [14:0]        win [WINDOW_DEPTH];
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_next;
  logic               full;
  logic               full_next;
  logic               wrap;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]   rounded;
  logic [14:0]        old;
  logic [PROD_W-1:0]  prod;
  logic [14:0]        avg;

  assign wrap      = (idx == LAST_IDX);
  assign idx_next  = wrap ? '0 : idx + IDX_W'(1);
  assign full_next = full | wrap;
  // the slot being replaced only counts once the window has filled
  assign old       = full ? win[idx] : '0;
  assign sum_next  = sum - SUM_W'(old) + SUM_W'(raw_q6);
  assign rounded   = sum_next + SUM_W'(WINDOW_DEPTH / 2);
  assign prod      = PROD_W'(rounded) * PROD_W'(RECIP_W'(RECIP));
  assign avg       = 15'(prod >> RECIP_SHIFT);
  assign filtered_q6 = full_next ? avg : raw_q6;

  always_ff @(posedge clk) begin
    if (write_en) begin
      win[idx] <= raw_q6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      full <= 1'b0;
      sum  <= '0;
    end else if (write_en) begin
      idx  <= idx_next;
      full <= full_next;
      sum  <= sum_next;
    end
  end

endmodule
